>>> design/radix_string_to_integer_top_assert.svh
// Assertion macros for the radix string parser top level.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef RADIX_STRING_TO_INTEGER_TOP_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RSTI_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RSTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rsti_pkg.sv
// Shared types, constants and the digit decoder for the radix string parser.
// No dependencies; imported by the top level, the controller and the datapath.
package rsti_pkg;

    localparam int ACC_WIDTH_DEF = 64;
    localparam int BASE_W        = 7;   // bases up to 64
    localparam int CNT_W         = $clog2(BASE_W);
    localparam int DIGIT_W       = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [7:0] RADIX_RESET    = 8'd10;
    localparam logic [7:0] BASE_MIN       = 8'd2;
    localparam logic [7:0] BASE_MAX       = 8'd64;
    localparam logic [7:0] BASE_ALNUM_MAX = 8'd36;
    localparam logic [7:0] BASE_FOLD_MAX  = 8'd38;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UZ  = 8'h5A;
    localparam logic [7:0] CH_LA  = 8'h61;

    // Offsets that close the gaps between the digit ranges
    localparam logic [7:0] UPPER_SHIFT      = CH_UA - CH_9 - 8'd1;
    localparam logic [7:0] FOLD_LOWER_SHIFT = CH_LA - CH_9 - 8'd1;
    localparam logic [7:0] LOWER_SHIFT      = (CH_LA - CH_UZ - 8'd1) + UPPER_SHIFT;

    localparam logic [APB_ADDR_W-1:0] ADDR_RADIX = 3'd0;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_ERR = 2'd1,
        STAT_OVF = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic take;
        logic mul_step;
        logic add_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_nul;
        logic go_mul;
        logic mul_done;
    } t_dp_sts;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    function automatic t_digit digit_decode(logic [7:0] c, logic [7:0] base);
        logic [7:0] v;
        logic [7:0] off;
        logic       ok;
        t_digit     res;
        ok = 1'b1;
        v  = c;
        if (c[7]) begin
            ok = 1'b0;
        end else if (c >= CH_LA) begin
            v = (base <= BASE_FOLD_MAX) ? c - FOLD_LOWER_SHIFT : c - LOWER_SHIFT;
        end else if (c > CH_UZ) begin
            ok = 1'b0;
        end else if (c >= CH_UA) begin
            v = c - UPPER_SHIFT;
        end else if (c > CH_9) begin
            ok = 1'b0;
        end
        off = (base > BASE_ALNUM_MAX) ? CH_DOT : CH_0;
        if (v < off) begin
            ok = 1'b0;
        end
        v = v - off;
        if (v >= base) begin
            ok = 1'b0;
        end
        res.ok    = ok;
        res.value = v[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

>>> design/rsti_char_if.sv
// Input byte channel: valid/ready handshake carrying one string byte.
// Standalone interface, no dependencies.
interface rsti_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

>>> design/rsti_result_if.sv
// Result channel: valid/ready handshake carrying the parsed value and status.
// Standalone interface; VALUE_W follows the accumulator width.
interface rsti_result_if #(
    parameter int VALUE_W = 64
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

>>> design/radix_string_to_integer_top.sv
// Top level of the radix string parser: APB radix register, controller, datapath.
// Depends on rsti_pkg, rsti_char_if, rsti_result_if, rsti_ctrl, rsti_dpath.
//
//   port      dir   handshake       carries
//   i_char    in    valid/ready     char_byte [7:0]
//   o_res     out   valid/ready     value [ACC_WIDTH-1:0], status [1:0]
//   APB       in    psel/penable    radix at byte address 0
//
// A digit byte is accepted and decoded, then takes seven shift-add steps over
// the base bits, then one step to add the digit and check the carry.
// A byte that is ignored after a fault, or a bad digit, is accepted without a multiply.
// A NUL moves to the finish state, which waits for the result register to empty.
// Synchronous active-low reset clears the state; radix resets to 10.
`include "radix_string_to_integer_top_assert.svh"

module radix_string_to_integer_top
    import rsti_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rsti_char_if.sink             i_char,
    rsti_result_if.source         o_res,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    logic [7:0]           r_radix;
    logic                 w_radix_sel;
    logic                 w_in_ready;
    logic                 w_out_valid;
    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    logic [ACC_WIDTH-1:0] w_value;
    logic [1:0]           w_status;

    // low two address bits select a byte within the word and are ignored
    assign w_radix_sel = (i_paddr[APB_ADDR_W-1:2] == ADDR_RADIX[APB_ADDR_W-1:2]);
    assign o_pready    = 1'b1;
    assign o_prdata    = w_radix_sel ? {{(APB_DATA_W - 8){1'b0}}, r_radix} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_radix_sel) begin
            r_radix <= i_pwdata[7:0];
        end
    end

    rsti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rsti_dpath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_byte (i_char.char_byte),
        .i_radix     (r_radix),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_value     (w_value),
        .o_status    (w_status)
    );

    assign i_char.ready = w_in_ready;
    assign o_res.valid  = w_out_valid;
    assign o_res.value  = w_value;
    assign o_res.status = w_status;

    `RSTI_ASSERT(a_fault_value_zero, o_res.valid && (o_res.status != STAT_OK), o_res.value == '0, "faulted result carries a nonzero value")
    `RSTI_ASSERT_NEXT(a_nul_blocks_input, i_char.valid && i_char.ready && (i_char.char_byte == CH_NUL), !i_char.ready, "input taken while a result is being formed")
    `RSTI_ASSERT(a_nul_gives_result, i_char.valid && i_char.ready && (i_char.char_byte == CH_NUL) && !o_res.valid, ##2 o_res.valid, "terminator did not produce a result")

endmodule

>>> design/rsti_ctrl.sv
// Controller state machine for the radix string parser.
// Depends on rsti_pkg; drives the datapath by command struct.
module rsti_ctrl
    import rsti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_finish;

    assign w_accept = (r_state == ST_IDLE) && i_in_valid;
    assign w_finish = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_sts.is_nul) begin
                    n_state = ST_FIN;
                end else if (w_accept && i_sts.go_mul) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.mul_done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_IDLE;
            end
            ST_FIN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.take     = w_accept && !i_sts.is_nul;
        o_cmd.mul_step = (r_state == ST_MUL);
        o_cmd.add_step = (r_state == ST_ADD);
        o_cmd.finish   = w_finish;
        // load the result register, or drop it once the transaction completes
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/rsti_dpath.sv
// Datapath: digit decode, shift-add multiply by the base, digit add, result register.
// Depends on rsti_pkg; sequenced by rsti_ctrl.
module rsti_dpath
    import rsti_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_char_byte,
    input  logic [7:0]           i_radix,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [ACC_WIDTH-1:0] o_value,
    output logic [1:0]           o_status
);

    localparam int PW = ACC_WIDTH + BASE_W;

    logic [ACC_WIDTH-1:0] r_acc;
    logic [ACC_WIDTH-1:0] n_acc;
    t_status              r_status;
    t_status              n_status;
    logic                 r_seen;
    logic                 n_seen;
    logic [BASE_W-1:0]    r_base;
    logic [DIGIT_W-1:0]   r_digit;
    logic [PW-1:0]        r_prod;
    logic [CNT_W-1:0]     r_bit_cnt;
    logic [ACC_WIDTH-1:0] r_out_value;
    t_status              r_out_status;
    t_status              w_final_status;
    t_digit               w_dig;
    logic                 w_base_ok;
    logic                 w_is_nul;
    logic [ACC_WIDTH:0]   w_sum;

    assign w_is_nul  = (i_char_byte == CH_NUL);
    assign w_base_ok = (i_radix >= BASE_MIN) && (i_radix <= BASE_MAX);
    assign w_dig     = digit_decode(i_char_byte, i_radix);
    assign w_sum     = {1'b0, r_prod[ACC_WIDTH-1:0]}
                     + {{(ACC_WIDTH + 1 - DIGIT_W){1'b0}}, r_digit};

    assign o_sts.is_nul   = w_is_nul;
    assign o_sts.go_mul   = !w_is_nul && (r_status == STAT_OK) && w_base_ok && w_dig.ok;
    assign o_sts.mul_done = (r_bit_cnt == '0);

    always_comb begin
        if (r_status != STAT_OK) begin
            w_final_status = r_status;
        end else if (!r_seen || !w_base_ok) begin
            w_final_status = STAT_ERR;
        end else begin
            w_final_status = STAT_OK;
        end
    end

    always_comb begin
        n_acc    = r_acc;
        n_status = r_status;
        n_seen   = r_seen;
        if (i_cmd.take) begin
            n_seen = 1'b1;
            if ((r_status == STAT_OK) && (!w_base_ok || !w_dig.ok)) begin
                n_status = STAT_ERR;
            end
        end
        if (i_cmd.add_step) begin
            // high product bits or a carry out of the digit add mean wrap
            if ((|r_prod[PW-1:ACC_WIDTH]) || w_sum[ACC_WIDTH]) begin
                n_status = STAT_OVF;
            end else begin
                n_acc = w_sum[ACC_WIDTH-1:0];
            end
        end
        if (i_cmd.finish) begin
            n_acc    = '0;
            n_status = STAT_OK;
            n_seen   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_status <= STAT_OK;
            r_seen   <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_status <= n_status;
            r_seen   <= n_seen;
        end
    end

    // MSB-first shift-add over the base bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_base    <= i_radix[BASE_W-1:0];
            r_digit   <= w_dig.value;
            r_prod    <= '0;
            r_bit_cnt <= CNT_W'(BASE_W - 1);
        end else if (i_cmd.mul_step) begin
            r_prod    <= {r_prod[PW-2:0], 1'b0}
                       + (r_base[r_bit_cnt] ? {{BASE_W{1'b0}}, r_acc} : PW'(0));
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= w_final_status;
            r_out_value  <= (w_final_status == STAT_OK) ? r_acc : '0;
        end
    end

    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule
